FILE: rtl/core/frame_time_window_statistics_defines.svh
// ---------------------------------------------------------------------------
// frame time window statistics assertion macros
// shared assertion wrappers, empty when SYNTHESIS is set
// ---------------------------------------------------------------------------
`ifndef FRAME_TIME_WINDOW_STATISTICS_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion with reset disable
`define FTWS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition implies a consequence in the next cycle
`define FTWS_ASSERT_NEXT(lbl, cond, cons, msg) \
    `FTWS_ASSERT_CLK(lbl, (cond) |=> (cons), msg)
`else
`define FTWS_ASSERT_CLK(lbl, prop, msg)
`define FTWS_ASSERT_NEXT(lbl, cond, cons, msg)
`endif

`endif

FILE: rtl/core/ftws_pkg.sv
// ---------------------------------------------------------------------------
// ftws_pkg
// types, constants and helpers of the frame time window statistics block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftws_pkg;

    // sizes
    localparam int WINDOW_MAX  = 64;
    localparam int TIME_BITS   = 24;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS    = TIME_BITS + IDX_BITS;
    localparam int FPS_BITS    = 20;
    localparam int FPS_NUM     = 1000000;
    localparam int DIVD_BITS   = (SUM_BITS > FPS_BITS) ? SUM_BITS : FPS_BITS;
    localparam int DIVS_BITS   = TIME_BITS;
    localparam int DIVC_BITS   = $clog2(DIVD_BITS + 1);
    localparam int WS_BITS     = 7;
    localparam int CTR_BITS    = 32;
    localparam int CFG_BITS    = TIME_BITS;

    // percentile rank constants, x/100 as (x*5243)>>19
    localparam int PCT_95      = 95;
    localparam int PCT_99      = 99;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    // register reset values
    localparam logic [WS_BITS-1:0]   WS_RESET     = WS_BITS'(60);
    localparam logic [TIME_BITS-1:0] BUDGET_RESET = TIME_BITS'(16667);
    localparam logic [TIME_BITS-1:0] THR_RESET    = TIME_BITS'(33333);

    // skip counts
    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_ONE  = 2'd1;
    localparam logic [1:0] SKIP_TWO  = 2'd2;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_END   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_BUDGET = 2'd1,
        CFG_ADAPT  = 2'd2,
        CFG_THRESH = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_CAND,
        S_CANDL,
        S_RANK,
        S_MEAN,
        S_MEAN_W,
        S_FPS,
        S_FPS_W,
        S_PUB
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIVD_BITS-1:0] dividend;
        logic [DIVS_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIVD_BITS-1:0] quotient;
    } t_div_rsp;

    // window register clamped to 1 .. WINDOW_MAX
    function automatic logic [CNT_BITS-1:0] eff_window(input logic [WS_BITS-1:0] ws);
        logic [31:0] ws_ext;
        ws_ext = 32'(ws);
        if (ws == '0) begin
            return CNT_BITS'(1);
        end else if (ws_ext > 32'(WINDOW_MAX)) begin
            return CNT_BITS'(WINDOW_MAX);
        end
        return CNT_BITS'(ws);
    endfunction

    // floor(pct*n/100) clamped to n-1
    function automatic logic [CNT_BITS-1:0] pick_rank(input logic [CNT_BITS-1:0] n,
                                                      input int pct);
        logic [31:0] x;
        logic [31:0] q;
        logic [31:0] n_ext;
        n_ext = 32'(n);
        x     = 32'(pct) * n_ext;
        q     = (x * 32'(RECIP_100)) >> RECIP_SHIFT;
        if (q >= n_ext) begin
            q = n_ext - 32'd1;
        end
        return CNT_BITS'(q);
    endfunction

endpackage

FILE: rtl/core/frame_time_window_statistics.sv
// ---------------------------------------------------------------------------
// frame_time_window_statistics
// frame time monitor: rolling min, max, mean, percentiles, fps and drops
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  kind, gpu and cpu times
//  out       output     o_out_valid / i_out_stall statistics of one item
//  cfg       input      i_cfg_we                 index, data
//
//  begin frame, reset and unused kinds go from idle straight to the publish state
//  end frame reads the n window entries through the single ring read port once
//  for the sum and once per candidate for rank counting, then up to two divisions
//  reset leaves the ring empty at once through per-entry valid bits
//  the input stalls while an item is at work; a finished beat waits in the
//  output register while the next item is taken
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_time_window_statistics_defines.svh"

module frame_time_window_statistics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [ftws_pkg::CFG_BITS-1:0]       i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [ftws_pkg::TIME_BITS-1:0]      i_gpu_time_us,
    input  logic [ftws_pkg::TIME_BITS-1:0]      i_cpu_elapsed_us,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_proceed,
    output logic                                o_drop_flag,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_excess_us,
    output logic [ftws_pkg::FPS_BITS-1:0]       o_frame_rate,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_mean_us,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_min_us,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_max_us,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_p95_us,
    output logic [ftws_pkg::TIME_BITS-1:0]      o_p99_us,
    output logic [ftws_pkg::CTR_BITS-1:0]       o_frames_total,
    output logic [ftws_pkg::CTR_BITS-1:0]       o_frames_dropped,
    output logic [1:0]                          o_skip_count
);

    localparam int TB = ftws_pkg::TIME_BITS;
    localparam int CB = ftws_pkg::CNT_BITS;
    localparam int IB = ftws_pkg::IDX_BITS;

    ftws_pkg::t_state r_state, n_state;

    // configuration registers
    logic [ftws_pkg::WS_BITS-1:0] r_window;
    logic [TB-1:0]                r_budget;
    logic                         r_adapt;
    logic [TB-1:0]                r_thresh;

    // statistics state
    logic [ftws_pkg::WINDOW_MAX-1:0] r_vld;
    logic [IB-1:0]                   r_ptr;
    logic [ftws_pkg::CTR_BITS-1:0]   r_frames;
    logic [ftws_pkg::CTR_BITS-1:0]   r_drops;
    logic [TB-1:0]                   r_held_mean;
    logic [TB-1:0]                   r_held_min;
    logic [TB-1:0]                   r_held_max;
    logic [TB-1:0]                   r_held_p95;
    logic [TB-1:0]                   r_held_p99;
    logic [ftws_pkg::FPS_BITS-1:0]   r_held_fps;

    // per item work registers
    logic [TB-1:0]                   r_sample;
    logic                            r_proceed;
    logic                            r_drop;
    logic [TB-1:0]                   r_excess;
    logic [CB-1:0]                   r_n;
    logic [CB-1:0]                   r_k95;
    logic [CB-1:0]                   r_k99;
    logic [CB-1:0]                   r_idx;
    logic [CB-1:0]                   r_j;
    logic                            r_pend;
    logic [ftws_pkg::SUM_BITS-1:0]   r_sum;
    logic [TB-1:0]                   r_mn;
    logic [TB-1:0]                   r_mx;
    logic [TB-1:0]                   r_cand;
    logic [CB-1:0]                   r_cl;
    logic [CB-1:0]                   r_cle;
    logic                            r_rd_vld;

    // output register
    logic                            r_out_valid;
    logic                            r_out_proceed;
    logic                            r_out_drop;
    logic [TB-1:0]                   r_out_excess;
    logic [ftws_pkg::FPS_BITS-1:0]   r_out_fps;
    logic [TB-1:0]                   r_out_mean;
    logic [TB-1:0]                   r_out_min;
    logic [TB-1:0]                   r_out_max;
    logic [TB-1:0]                   r_out_p95;
    logic [TB-1:0]                   r_out_p99;
    logic [ftws_pkg::CTR_BITS-1:0]   r_out_frames;
    logic [ftws_pkg::CTR_BITS-1:0]   r_out_drops;
    logic [1:0]                      r_out_skip;

    // combinational helpers
    logic                            in_acc;
    logic                            pub_load;
    logic [CB-1:0]                   w_eff;
    logic [IB-1:0]                   ptr_eff;
    logic [IB-1:0]                   ptr_nxt;
    logic [CB-1:0]                   n_calc;
    logic                            issue;
    logic                            scan_done;
    logic [TB-1:0]                   ram_q;
    logic [TB-1:0]                   rd_val;
    logic [IB-1:0]                   rd_addr;
    logic                            ram_we;
    logic [1:0]                      skip;
    logic [TB+1:0]                   mean_ext;
    logic [TB+1:0]                   two_mean;
    logic [TB+1:0]                   two_bud;
    logic [TB+1:0]                   three_bud;
    ftws_pkg::t_div_req              div_req;
    ftws_pkg::t_div_rsp              div_rsp;

    // ring memory and shared divider
    ftws_ram #(
        .WIDTH (TB),
        .DEPTH (ftws_pkg::WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ptr_eff),
        .i_wdata (r_sample),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    ftws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // window, pointer and entry count
    always_comb begin
        w_eff   = ftws_pkg::eff_window(r_window);
        ptr_eff = (CB'(r_ptr) >= w_eff) ? '0 : r_ptr;
        ptr_nxt = ((CB'(ptr_eff) + CB'(1)) == w_eff) ? '0 : (ptr_eff + IB'(1));
        n_calc  = (r_frames < ftws_pkg::CTR_BITS'(w_eff)) ? r_frames[CB-1:0] : w_eff;
    end

    // scan control and masked read data
    always_comb begin
        issue     = (r_idx < r_n);
        scan_done = (r_idx == r_n) && !r_pend;
        rd_val    = r_rd_vld ? ram_q : '0;
    end

    // skip decision on the held mean
    always_comb begin
        mean_ext  = (TB + 2)'(r_held_mean);
        two_mean  = mean_ext << 1;
        two_bud   = (TB + 2)'(r_budget) << 1;
        three_bud = two_bud + (TB + 2)'(r_budget);
        if (!r_adapt) begin
            skip = ftws_pkg::SKIP_NONE;
        end else if (mean_ext > two_bud) begin
            skip = ftws_pkg::SKIP_TWO;
        end else if (two_mean > three_bud) begin
            skip = ftws_pkg::SKIP_ONE;
        end else begin
            skip = ftws_pkg::SKIP_NONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftws_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_kind == ftws_pkg::KIND_END) ? ftws_pkg::S_WRITE
                                                              : ftws_pkg::S_PUB;
                end
            end
            ftws_pkg::S_WRITE: begin
                n_state = (n_calc == '0) ? ftws_pkg::S_FPS : ftws_pkg::S_SUM;
            end
            ftws_pkg::S_SUM: begin
                if (scan_done) n_state = ftws_pkg::S_CAND;
            end
            ftws_pkg::S_CAND:  n_state = ftws_pkg::S_CANDL;
            ftws_pkg::S_CANDL: n_state = ftws_pkg::S_RANK;
            ftws_pkg::S_RANK: begin
                if (scan_done) begin
                    n_state = ((r_j + CB'(1)) == r_n) ? ftws_pkg::S_MEAN : ftws_pkg::S_CAND;
                end
            end
            ftws_pkg::S_MEAN:  n_state = ftws_pkg::S_MEAN_W;
            ftws_pkg::S_MEAN_W: begin
                if (div_rsp.done) n_state = ftws_pkg::S_FPS;
            end
            ftws_pkg::S_FPS: begin
                n_state = (r_sample == '0) ? ftws_pkg::S_PUB : ftws_pkg::S_FPS_W;
            end
            ftws_pkg::S_FPS_W: begin
                if (div_rsp.done) n_state = ftws_pkg::S_PUB;
            end
            ftws_pkg::S_PUB: begin
                if (pub_load) n_state = ftws_pkg::S_IDLE;
            end
            default: n_state = ftws_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall       = (r_state != ftws_pkg::S_IDLE);
        in_acc           = i_in_valid && (r_state == ftws_pkg::S_IDLE);
        pub_load         = (r_state == ftws_pkg::S_PUB) && (!r_out_valid || !i_out_stall);
        ram_we           = (r_state == ftws_pkg::S_WRITE);
        rd_addr          = (r_state == ftws_pkg::S_CAND) ? r_j[IB-1:0] : r_idx[IB-1:0];
        div_req.start    = (r_state == ftws_pkg::S_MEAN) ||
                           ((r_state == ftws_pkg::S_FPS) && (r_sample != '0));
        div_req.dividend = (r_state == ftws_pkg::S_MEAN)
                           ? ftws_pkg::DIVD_BITS'(r_sum)
                           : ftws_pkg::DIVD_BITS'(ftws_pkg::FPS_NUM);
        div_req.divisor  = (r_state == ftws_pkg::S_MEAN)
                           ? ftws_pkg::DIVS_BITS'(r_n)
                           : r_sample;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= ftws_pkg::WS_RESET;
            r_budget <= ftws_pkg::BUDGET_RESET;
            r_adapt  <= 1'b0;
            r_thresh <= ftws_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ftws_pkg::CFG_WINDOW: r_window <= i_cfg_data[ftws_pkg::WS_BITS-1:0];
                ftws_pkg::CFG_BUDGET: r_budget <= i_cfg_data[TB-1:0];
                ftws_pkg::CFG_ADAPT:  r_adapt  <= i_cfg_data[0];
                ftws_pkg::CFG_THRESH: r_thresh <= i_cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    // valid bit of the entry being read
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[rd_addr];
    end

    // statistics state and held results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_ptr       <= '0;
            r_frames    <= '0;
            r_drops     <= '0;
            r_held_mean <= '0;
            r_held_min  <= '1;
            r_held_max  <= '0;
            r_held_p95  <= '0;
            r_held_p99  <= '0;
            r_held_fps  <= '0;
        end else begin
            case (r_state)
                ftws_pkg::S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            ftws_pkg::KIND_BEGIN: begin
                                if (r_frames != '1) r_frames <= r_frames + 1'b1;
                            end
                            ftws_pkg::KIND_CLEAR: begin
                                r_vld       <= '0;
                                r_ptr       <= '0;
                                r_frames    <= '0;
                                r_drops     <= '0;
                                r_held_mean <= '0;
                                r_held_min  <= '1;
                                r_held_max  <= '0;
                                r_held_p95  <= '0;
                                r_held_p99  <= '0;
                                r_held_fps  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ftws_pkg::S_WRITE: begin
                    r_vld[ptr_eff] <= 1'b1;
                    r_ptr          <= ptr_nxt;
                    if ((r_sample > r_budget) && (r_drops != '1)) begin
                        r_drops <= r_drops + 1'b1;
                    end
                    // empty window gives the cleared statistics
                    if (n_calc == '0) begin
                        r_held_mean <= '0;
                        r_held_min  <= '1;
                        r_held_max  <= '0;
                        r_held_p95  <= '0;
                        r_held_p99  <= '0;
                    end
                end
                ftws_pkg::S_SUM: begin
                    if (scan_done) begin
                        r_held_min <= r_mn;
                        r_held_max <= r_mx;
                    end
                end
                ftws_pkg::S_RANK: begin
                    if (scan_done) begin
                        if ((r_cl <= r_k95) && (r_k95 < r_cle)) r_held_p95 <= r_cand;
                        if ((r_cl <= r_k99) && (r_k99 < r_cle)) r_held_p99 <= r_cand;
                    end
                end
                ftws_pkg::S_MEAN_W: begin
                    if (div_rsp.done) r_held_mean <= div_rsp.quotient[TB-1:0];
                end
                ftws_pkg::S_FPS: begin
                    if (r_sample == '0) r_held_fps <= '0;
                end
                ftws_pkg::S_FPS_W: begin
                    if (div_rsp.done) r_held_fps <= div_rsp.quotient[ftws_pkg::FPS_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // per item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ftws_pkg::S_IDLE: begin
                r_proceed <= 1'b1;
                r_drop    <= 1'b0;
                r_excess  <= '0;
                if (i_kind == ftws_pkg::KIND_BEGIN) begin
                    r_proceed <= !(r_adapt && (r_held_mean > r_thresh));
                end
                r_sample <= (i_gpu_time_us != '0) ? i_gpu_time_us : i_cpu_elapsed_us;
            end
            ftws_pkg::S_WRITE: begin
                if (r_sample > r_budget) begin
                    r_drop   <= 1'b1;
                    r_excess <= r_sample - r_budget;
                end
                r_n    <= n_calc;
                r_k95  <= ftws_pkg::pick_rank(n_calc, ftws_pkg::PCT_95);
                r_k99  <= ftws_pkg::pick_rank(n_calc, ftws_pkg::PCT_99);
                r_idx  <= '0;
                r_j    <= '0;
                r_pend <= 1'b0;
                r_sum  <= '0;
                r_mn   <= '1;
                r_mx   <= '0;
            end
            // sum, min and max pass
            ftws_pkg::S_SUM: begin
                if (issue) r_idx <= r_idx + CB'(1);
                r_pend <= issue;
                if (r_pend) begin
                    r_sum <= r_sum + ftws_pkg::SUM_BITS'(rd_val);
                    if (rd_val < r_mn) r_mn <= rd_val;
                    if (rd_val > r_mx) r_mx <= rd_val;
                end
            end
            // candidate fetch for rank counting
            ftws_pkg::S_CANDL: begin
                r_cand <= rd_val;
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_cl   <= '0;
                r_cle  <= '0;
            end
            ftws_pkg::S_RANK: begin
                if (issue) r_idx <= r_idx + CB'(1);
                r_pend <= issue;
                if (r_pend) begin
                    if (rd_val < r_cand)  r_cl  <= r_cl + CB'(1);
                    if (rd_val <= r_cand) r_cle <= r_cle + CB'(1);
                end
                if (scan_done) r_j <= r_j + CB'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pub_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pub_load) begin
            r_out_proceed <= r_proceed;
            r_out_drop    <= r_drop;
            r_out_excess  <= r_excess;
            r_out_fps     <= r_held_fps;
            r_out_mean    <= r_held_mean;
            r_out_min     <= r_held_min;
            r_out_max     <= r_held_max;
            r_out_p95     <= r_held_p95;
            r_out_p99     <= r_held_p99;
            r_out_frames  <= r_frames;
            r_out_drops   <= r_drops;
            r_out_skip    <= skip;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_proceed        = r_out_proceed;
    assign o_drop_flag      = r_out_drop;
    assign o_excess_us      = r_out_excess;
    assign o_frame_rate     = r_out_fps;
    assign o_mean_us        = r_out_mean;
    assign o_min_us         = r_out_min;
    assign o_max_us         = r_out_max;
    assign o_p95_us         = r_out_p95;
    assign o_p99_us         = r_out_p99;
    assign o_frames_total   = r_out_frames;
    assign o_frames_dropped = r_out_drops;
    assign o_skip_count     = r_out_skip;

    // checks
    `FTWS_ASSERT_CLK(a_div_done_wait,
        div_rsp.done |-> ((r_state == ftws_pkg::S_MEAN_W) || (r_state == ftws_pkg::S_FPS_W)),
        "divider finished outside a wait state")
    `FTWS_ASSERT_NEXT(a_end_to_write, in_acc && (i_kind == ftws_pkg::KIND_END),
        r_state == ftws_pkg::S_WRITE, "end frame did not start the ring write")
    `FTWS_ASSERT_NEXT(a_pub_loads, (r_state == ftws_pkg::S_PUB) && !r_out_valid,
        r_out_valid, "publish with free output register lost the beat")
    `FTWS_ASSERT_CLK(a_rank_order, (r_state == ftws_pkg::S_RANK) |-> (r_cl <= r_cle),
        "rank counts out of order")

endmodule

FILE: rtl/core/ftws_ram.sv
// ---------------------------------------------------------------------------
// ftws_ram
// generic single write, single registered read memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ftws_div.sv
// ---------------------------------------------------------------------------
// ftws_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftws_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftws_pkg::t_div_req  i_req,
    output ftws_pkg::t_div_rsp  o_rsp
);

    logic [ftws_pkg::DIVS_BITS:0]   r_rem;
    logic [ftws_pkg::DIVD_BITS-1:0] r_quo;
    logic [ftws_pkg::DIVS_BITS-1:0] r_dvs;
    logic [ftws_pkg::DIVC_BITS-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [ftws_pkg::DIVS_BITS:0]   shifted;
    logic [ftws_pkg::DIVS_BITS:0]   dvs_ext;
    logic                           ge;

    // trial subtract
    always_comb begin
        shifted = {r_rem[ftws_pkg::DIVS_BITS-1:0], r_quo[ftws_pkg::DIVD_BITS-1]};
        dvs_ext = {1'b0, r_dvs};
        ge      = (shifted >= dvs_ext);
    end

    // iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_cnt  <= ftws_pkg::DIVC_BITS'(ftws_pkg::DIVD_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? (shifted - dvs_ext) : shifted;
                r_quo <= {r_quo[ftws_pkg::DIVD_BITS-2:0], ge};
                r_cnt <= r_cnt - ftws_pkg::DIVC_BITS'(1);
                if (r_cnt == ftws_pkg::DIVC_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
